@@ src/sd_card_spi_host_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// sd card spi host sequencer assertion macros
// shared property wrappers for the concurrent checks of the sequencer
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_SEQUENCER_DEFINES_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDSH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdsh same-cycle check failed");

// next-cycle implication, disabled during reset
`define SDSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdsh next-cycle check failed");

`endif

@@ src/sdsh_pkg.sv @@
// ----------------------------------------------------------------------------
// sdsh_pkg
// types, codes and helpers shared by the sd card spi host sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsh_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int BUF_AW       = $clog2(SECTOR_BYTES);
  localparam int BC_W         = BUF_AW + 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = QUEUE_AW + 1;

  // request operations
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_LOAD  = 3'd3;
  localparam logic [2:0] OP_RX    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // job status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CMD0_FAIL = 3'd1;
  localparam logic [2:0] ST_CMD1_FAIL = 3'd2;
  localparam logic [2:0] ST_WCMD_FAIL = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;
  localparam logic [2:0] ST_RCMD_FAIL = 3'd5;

  // command bytes and fixed tokens
  localparam logic [7:0] CMD0_CODE   = 8'h40;
  localparam logic [7:0] CMD1_CODE   = 8'h41;
  localparam logic [7:0] CMD17_CODE  = 8'h51;
  localparam logic [7:0] CMD24_CODE  = 8'h58;
  localparam logic [7:0] CMD0_CRC    = 8'h95;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] DATA_TOKEN  = 8'hFE;
  localparam logic [7:0] RESP_MASK   = 8'h1F;
  localparam logic [7:0] RESP_OK     = 8'h05;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_INIT_CLOCKS = 2'd2;
  localparam logic [1:0] CFG_WRITE_GAP   = 2'd3;

  localparam logic [9:0] RETRY_LIMIT_RST = 10'd800;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd200;
  localparam logic [7:0] INIT_CLOCKS_RST = 8'h2f;
  localparam logic [7:0] WRITE_GAP_RST   = 8'd100;

  typedef enum logic [4:0] {
    PH_IDLE, PH_INIT_CLK, PH_SYNC, PH_CODE, PH_ARG, PH_CRC, PH_GAP, PH_POLL,
    PH_W_GAP, PH_W_TOKEN, PH_W_DATA, PH_W_CRC, PH_W_RESP, PH_W_BUSY,
    PH_R_TOKEN, PH_R_DATA
  } phase_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [22:0] sector;
    logic [7:0]  data_byte;
    logic [8:0]  byte_index;
  } sdsh_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] read_byte;
    logic [2:0] status;
    logic       last;
  } sdsh_rsp_t;

  typedef struct packed {
    logic [QUEUE_CW-1:0] count;
    logic                room_for_two;
  } sdsh_queue_status_t;

  // result builders, each marked last until a second result follows
  function automatic sdsh_rsp_t mk_tx(input logic [7:0] tx, input logic cs);
    sdsh_rsp_t r;
    r = '0;
    r.kind        = KIND_TX;
    r.tx_byte     = tx;
    r.chip_select = cs;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic sdsh_rsp_t mk_data(input logic [7:0] rd);
    sdsh_rsp_t r;
    r = '0;
    r.kind      = KIND_DATA;
    r.read_byte = rd;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic sdsh_rsp_t mk_done(input logic [2:0] st);
    sdsh_rsp_t r;
    r = '0;
    r.kind        = KIND_DONE;
    r.chip_select = 1'b1;
    r.status      = st;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

@@ src/sdsh_result_queue.sv @@
// ----------------------------------------------------------------------------
// sdsh_result_queue
// small result queue taking up to two entries per cycle and giving one when rsp_ready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsh_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_count,
  input  sdsh_pkg::sdsh_rsp_t        push0,
  input  sdsh_pkg::sdsh_rsp_t        push1,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output sdsh_pkg::sdsh_rsp_t        rsp,
  output sdsh_pkg::sdsh_queue_status_t status
);
  import sdsh_pkg::*;

  sdsh_rsp_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head;
  logic [QUEUE_AW-1:0] tail;
  logic [QUEUE_CW-1:0] count;
  logic [QUEUE_AW-1:0] tail_plus1;
  logic                pop;

  assign tail_plus1 = tail + 1'b1;
  assign pop        = rsp_valid && rsp_ready;
  assign rsp_valid  = (count != '0);
  assign rsp        = entries[head];

  assign status.count        = count;
  assign status.room_for_two = (count <= QUEUE_CW'(QUEUE_DEPTH - 2));

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QUEUE_AW'(pop);
      tail  <= tail + QUEUE_AW'(push_count);
      count <= count + QUEUE_CW'(push_count) - QUEUE_CW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[tail] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[tail_plus1] <= push1;
    end
  end

endmodule

@@ src/sd_card_spi_host_sequencer.sv @@
// Results: a request is decoded on the edge that accepts it; its results sit in the
// result queue and appear on rsp from the next cycle on, one per cycle while rsp_ready is high.
// Throughput: one request per cycle while the four-entry result queue has room for two
// results; a received data byte yields two results.
// Reset: phase and counters cleared, registers back to their defaults, queue emptied;
// the sector buffer is not cleared and holds whatever was last loaded.
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// spi mode sd card host, at most one exchanged byte per request: init, read, write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sd_card_spi_host_sequencer_defines.svh"

module sd_card_spi_host_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sdsh_pkg::sdsh_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sdsh_pkg::sdsh_rsp_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import sdsh_pkg::*;

  // configuration
  logic [9:0] retry_limit;
  logic [7:0] poll_limit;
  logic [7:0] init_clock_bytes;
  logic [7:0] write_gap_bytes;

  // sequencer state
  phase_t      phase,          phase_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [9:0]  retry_count,    retry_count_next;
  logic [7:0]  poll_count,     poll_count_next;
  logic [7:0]  command_code,   command_code_next;
  logic [31:0] argument_shift, argument_shift_next;

  // sector buffer
  logic [7:0]        write_buffer [SECTOR_BYTES];
  logic [7:0]        buf_q;
  logic [BUF_AW-1:0] buf_addr_next;
  logic              buf_we;

  // per-request results
  sdsh_rsp_t          res0;
  sdsh_rsp_t          res1;
  logic [1:0]         n_res;
  logic               req_fire;
  logic [7:0]         rx;
  logic [7:0]         poll_inc;
  logic [BC_W-1:0]    bc_inc;
  logic [7:0]         expect_r1;
  logic [2:0]         fail_status;
  sdsh_queue_status_t q_status;

  // check terms
  logic               start_busy;
  logic               token_rx;
  logic               token_state;

  assign cfg_ready = 1'b1;
  assign req_ready = q_status.room_for_two;
  assign req_fire  = req_valid && req_ready;
  assign rx        = req.data_byte;
  assign poll_inc  = poll_count + 8'd1;
  assign bc_inc    = byte_count + 1'b1;
  assign expect_r1 = (command_code == CMD0_CODE) ? R1_IDLE : R1_READY;

  always_comb begin
    case (command_code)
      CMD0_CODE:  fail_status = ST_CMD0_FAIL;
      CMD1_CODE:  fail_status = ST_CMD1_FAIL;
      CMD24_CODE: fail_status = ST_WCMD_FAIL;
      default:    fail_status = ST_RCMD_FAIL;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit      <= RETRY_LIMIT_RST;
      poll_limit       <= POLL_LIMIT_RST;
      init_clock_bytes <= INIT_CLOCKS_RST;
      write_gap_bytes  <= WRITE_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit      <= cfg_data;
        CFG_POLL_LIMIT:  poll_limit       <= cfg_data[7:0];
        CFG_INIT_CLOCKS: init_clock_bytes <= cfg_data[7:0];
        CFG_WRITE_GAP:   write_gap_bytes  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state and results of the accepted request
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    retry_count_next    = retry_count;
    poll_count_next     = poll_count;
    command_code_next   = command_code;
    argument_shift_next = argument_shift;
    res0   = '0;
    res1   = '0;
    n_res  = 2'd0;
    buf_we = 1'b0;
    if (req_fire) begin
      case (req.operation)
        OP_LOAD: begin
          buf_we = 1'b1;
        end
        OP_INIT: begin
          if (phase == PH_IDLE) begin
            n_res = 2'd1;
            res0  = mk_tx(IDLE_BYTE, 1'b1);
            if (init_clock_bytes != 8'd0) begin
              phase_next      = PH_INIT_CLK;
              byte_count_next = BC_W'(1);
            end else begin
              command_code_next   = CMD0_CODE;
              argument_shift_next = '0;
              retry_count_next    = '0;
              poll_count_next     = '0;
              phase_next          = PH_SYNC;
            end
          end
        end
        OP_READ, OP_WRITE: begin
          if (phase == PH_IDLE) begin
            n_res               = 2'd1;
            res0                = mk_tx(IDLE_BYTE, 1'b1);
            command_code_next   = (req.operation == OP_READ) ? CMD17_CODE : CMD24_CODE;
            argument_shift_next = {req.sector, 9'd0};
            retry_count_next    = '0;
            poll_count_next     = '0;
            phase_next          = PH_SYNC;
          end
        end
        OP_RX: begin
          n_res = 2'd1;
          case (phase)
            PH_INIT_CLK: begin
              res0 = mk_tx(IDLE_BYTE, 1'b1);
              if (byte_count < BC_W'(init_clock_bytes)) begin
                byte_count_next = bc_inc;
              end else begin
                command_code_next   = CMD0_CODE;
                argument_shift_next = '0;
                retry_count_next    = '0;
                poll_count_next     = '0;
                phase_next          = PH_SYNC;
              end
            end
            PH_SYNC: begin
              phase_next = PH_CODE;
              res0       = mk_tx(command_code, 1'b0);
            end
            PH_CODE: begin
              phase_next          = PH_ARG;
              byte_count_next     = BC_W'(1);
              res0                = mk_tx(argument_shift[31:24], 1'b0);
              argument_shift_next = {argument_shift[23:0], argument_shift[31:24]};
            end
            PH_ARG: begin
              if (byte_count < BC_W'(4)) begin
                res0                = mk_tx(argument_shift[31:24], 1'b0);
                argument_shift_next = {argument_shift[23:0], argument_shift[31:24]};
                byte_count_next     = bc_inc;
              end else begin
                phase_next = PH_CRC;
                res0 = mk_tx((command_code == CMD0_CODE) ? CMD0_CRC : IDLE_BYTE, 1'b0);
              end
            end
            PH_CRC: begin
              phase_next = PH_GAP;
              res0       = mk_tx(IDLE_BYTE, 1'b0);
            end
            PH_GAP: begin
              phase_next      = PH_POLL;
              poll_count_next = '0;
              res0            = mk_tx(IDLE_BYTE, 1'b0);
            end
            PH_POLL: begin
              poll_count_next = poll_inc;
              if (rx == IDLE_BYTE && poll_inc < poll_limit) begin
                res0 = mk_tx(IDLE_BYTE, 1'b0);
              end else if (retry_count >= retry_limit) begin
                // out of tries: fail whatever the card answered
                phase_next = PH_IDLE;
                res0       = mk_done(fail_status);
              end else begin
                retry_count_next = retry_count + 10'd1;
                if (rx != expect_r1) begin
                  // resend the same command
                  poll_count_next = '0;
                  phase_next      = PH_SYNC;
                  res0            = mk_tx(IDLE_BYTE, 1'b1);
                end else begin
                  case (command_code)
                    CMD0_CODE: begin
                      command_code_next   = CMD1_CODE;
                      argument_shift_next = '0;
                      retry_count_next    = '0;
                      poll_count_next     = '0;
                      phase_next          = PH_SYNC;
                      res0                = mk_tx(IDLE_BYTE, 1'b1);
                    end
                    CMD1_CODE: begin
                      phase_next = PH_IDLE;
                      res0       = mk_done(ST_OK);
                    end
                    CMD24_CODE: begin
                      if (write_gap_bytes != 8'd0) begin
                        phase_next      = PH_W_GAP;
                        byte_count_next = BC_W'(1);
                        res0            = mk_tx(IDLE_BYTE, 1'b0);
                      end else begin
                        phase_next = PH_W_TOKEN;
                        res0       = mk_tx(DATA_TOKEN, 1'b0);
                      end
                    end
                    default: begin
                      phase_next = PH_R_TOKEN;
                      res0       = mk_tx(IDLE_BYTE, 1'b0);
                    end
                  endcase
                end
              end
            end
            PH_W_GAP: begin
              if (byte_count < BC_W'(write_gap_bytes)) begin
                byte_count_next = bc_inc;
                res0            = mk_tx(IDLE_BYTE, 1'b0);
              end else begin
                phase_next = PH_W_TOKEN;
                res0       = mk_tx(DATA_TOKEN, 1'b0);
              end
            end
            PH_W_TOKEN: begin
              phase_next      = PH_W_DATA;
              byte_count_next = BC_W'(1);
              res0            = mk_tx(buf_q, 1'b0);
            end
            PH_W_DATA: begin
              if (byte_count < BC_W'(SECTOR_BYTES)) begin
                res0            = mk_tx(buf_q, 1'b0);
                byte_count_next = bc_inc;
              end else begin
                phase_next      = PH_W_CRC;
                byte_count_next = BC_W'(1);
                res0            = mk_tx(IDLE_BYTE, 1'b0);
              end
            end
            PH_W_CRC: begin
              res0 = mk_tx(IDLE_BYTE, 1'b0);
              if (byte_count < BC_W'(2)) begin
                byte_count_next = bc_inc;
              end else begin
                phase_next = PH_W_RESP;
              end
            end
            PH_W_RESP: begin
              if ((rx & RESP_MASK) != RESP_OK) begin
                phase_next = PH_IDLE;
                res0       = mk_done(ST_REJECTED);
              end else begin
                phase_next = PH_W_BUSY;
                res0       = mk_tx(IDLE_BYTE, 1'b0);
              end
            end
            PH_W_BUSY: begin
              if (rx == IDLE_BYTE) begin
                phase_next = PH_IDLE;
                res0       = mk_done(ST_OK);
              end else begin
                res0 = mk_tx(IDLE_BYTE, 1'b0);
              end
            end
            PH_R_TOKEN: begin
              res0 = mk_tx(IDLE_BYTE, 1'b0);
              if (rx == DATA_TOKEN) begin
                phase_next      = PH_R_DATA;
                byte_count_next = '0;
              end
            end
            PH_R_DATA: begin
              // data byte out, then either the next clock byte or done
              n_res           = 2'd2;
              res0            = mk_data(rx);
              byte_count_next = bc_inc;
              if (bc_inc >= BC_W'(SECTOR_BYTES)) begin
                phase_next = PH_IDLE;
                res1       = mk_done(ST_OK);
              end else begin
                res1 = mk_tx(IDLE_BYTE, 1'b0);
              end
            end
            default: begin
              n_res = 2'd0;
            end
          endcase
        end
        default: ;
      endcase
    end
    if (n_res == 2'd2) begin
      res0.last = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_count     <= '0;
      retry_count    <= '0;
      poll_count     <= '0;
      command_code   <= '0;
      argument_shift <= '0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      retry_count    <= retry_count_next;
      poll_count     <= poll_count_next;
      command_code   <= command_code_next;
      argument_shift <= argument_shift_next;
    end
  end

  // buffer prefetch: fetch the byte the data phase will send next
  assign buf_addr_next = (phase_next == PH_W_DATA) ? byte_count_next[BUF_AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      write_buffer[req.byte_index] <= req.data_byte;
    end
    if (buf_we && req.byte_index == buf_addr_next) begin
      buf_q <= req.data_byte;
    end else begin
      buf_q <= write_buffer[buf_addr_next];
    end
  end

  // result queue
  sdsh_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (n_res),
    .push0      (res0),
    .push1      (res1),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .status     (q_status)
  );

  // terms for the checks
  assign start_busy  = req_fire && phase != PH_IDLE &&
                       (req.operation == OP_INIT || req.operation == OP_READ ||
                        req.operation == OP_WRITE);
  assign token_rx    = req_fire && req.operation == OP_RX && phase == PH_R_TOKEN;
  assign token_state = phase == PH_R_TOKEN || (phase == PH_R_DATA && byte_count == '0);

  // checks
  `SDSH_ASSERT_IMPL(a_ready_room, clk, rst, req_ready, q_status.count <= QUEUE_CW'(QUEUE_DEPTH - 2))
  `SDSH_ASSERT_NEXT(a_busy_start, clk, rst, start_busy, $stable(phase))
  `SDSH_ASSERT_NEXT(a_token_wait, clk, rst, token_rx, token_state)

endmodule
